// ===== rtl/core/pclce_pkg.sv =====
// Package for the page cache with LRU clean eviction.
// Holds item types, entry layout, opcodes, status codes and controller states.
// No dependencies.
`default_nettype none
package pclce_pkg;

  localparam int NUM_FRAMES_DEF   = 64;
  localparam int NUM_SEGMENTS_DEF = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 8;

  localparam logic [7:0] MAX_LEN_RST     = 8'd10;
  localparam logic [6:0] FRAME_COUNT_RST = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd1;

  localparam logic [2:0] OP_LOOKUP  = 3'd0;
  localparam logic [2:0] OP_INSERT  = 3'd1;
  localparam logic [2:0] OP_UPDATE  = 3'd2;
  localparam logic [2:0] OP_DROP    = 3'd3;
  localparam logic [2:0] OP_JOURNAL = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_MISS    = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_LONG    = 3'd3;
  localparam logic [2:0] ST_NODIRTY = 3'd4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  segment_id;
    logic [15:0] page_key;
    logic [63:0] value_stamp;
    logic [63:0] now_time;
    logic        dirty_in;
    logic [7:0]  value_length;
    logic [5:0]  frame_sel;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  frame_out;
    logic [3:0]  seg_out;
    logic [15:0] key_out;
    logic [63:0] stamp_out;
    logic        evicted;
    logic [3:0]  evicted_seg;
    logic [15:0] evicted_key;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  seg;
    logic [15:0] key;
    logic [63:0] stamp;
    logic [63:0] last_use;
  } frame_ent_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_start;
    logic issue;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;
    logic issue_last;
    logic hit_stop;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/pclce_ctrl.sv =====
// Controller of the page cache: sequences check, frame scan, drain and commit.
// Depends on pclce_pkg.
`default_nettype none
module pclce_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire pclce_pkg::dp_stat_t stat,
  output pclce_pkg::dp_cmd_t     cmd
);

  pclce_pkg::state_t state_r, state_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pclce_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pclce_pkg::S_IDLE: begin
        if (start) state_nxt = pclce_pkg::S_CHECK;
      end
      pclce_pkg::S_CHECK: begin
        state_nxt = stat.need_scan ? pclce_pkg::S_SCAN : pclce_pkg::S_COMMIT;
      end
      pclce_pkg::S_SCAN: begin
        if (stat.hit_stop) state_nxt = pclce_pkg::S_COMMIT;
        else if (stat.issue_last) state_nxt = pclce_pkg::S_DRAIN;
      end
      pclce_pkg::S_DRAIN:  state_nxt = pclce_pkg::S_COMMIT;
      pclce_pkg::S_COMMIT: state_nxt = pclce_pkg::S_IDLE;
      default:             state_nxt = pclce_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      pclce_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      pclce_pkg::S_CHECK:  cmd.scan_start = stat.need_scan;
      pclce_pkg::S_SCAN:   cmd.issue = 1'b1;
      pclce_pkg::S_DRAIN:  cmd = '0;
      pclce_pkg::S_COMMIT: cmd.commit = 1'b1;
      default:             busy = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/pclce_dp.sv =====
// Datapath of the page cache: config registers, frame memory, valid/dirty bits,
// scan pipeline, victim tracking and result register. Depends on pclce_pkg.
`default_nettype none
module pclce_dp #(
  parameter int NUM_FRAMES   = pclce_pkg::NUM_FRAMES_DEF,
  parameter int NUM_SEGMENTS = pclce_pkg::NUM_SEGMENTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire pclce_pkg::in_item_t               in_item,
  input  wire logic                              cfg_we,
  input  wire logic [pclce_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [pclce_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire pclce_pkg::dp_cmd_t                cmd,
  output pclce_pkg::dp_stat_t                    stat,
  output logic                                   out_valid,
  output pclce_pkg::out_item_t                   out_item
);

  localparam int FW      = $clog2(NUM_FRAMES);
  localparam int CW      = FW + 1;
  localparam int ACT_MAX = (NUM_FRAMES < 64) ? NUM_FRAMES : 64;

  logic [7:0] max_len_r;
  logic [6:0] frame_count_r;
  pclce_pkg::in_item_t req_r;

  logic [NUM_FRAMES-1:0] valid_r;
  logic [NUM_FRAMES-1:0] dirty_r;
  pclce_pkg::frame_ent_t ram [NUM_FRAMES];
  pclce_pkg::frame_ent_t rd_q;

  logic [CW-1:0] addr_r;
  logic          eval_vld_r;
  logic [FW-1:0] eval_idx_r;

  logic                  found_r;
  logic [FW-1:0]         hit_idx_r;
  pclce_pkg::frame_ent_t hit_data_r;
  logic                  best_vld_r;
  logic [FW-1:0]         best_idx_r;
  pclce_pkg::frame_ent_t best_data_r;
  logic                  any_r;

  logic                 out_valid_r;
  pclce_pkg::out_item_t out_r;

  logic [6:0]  n7;
  logic [CW-1:0] n_c;
  logic        seg_ok, len_ok, sel_ok;
  logic        e_valid, e_dirty, e_seg_eq, e_key_eq;
  logic        lu_better;
  logic        emit_vld;
  pclce_pkg::out_item_t emit_item;
  logic        wr_en;
  logic [FW-1:0] wr_idx;
  pclce_pkg::frame_ent_t wr_data;
  logic        wr_dirty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r     <= pclce_pkg::MAX_LEN_RST;
      frame_count_r <= pclce_pkg::FRAME_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        pclce_pkg::REG_MAX_LEN:     max_len_r <= cfg_wdata;
        pclce_pkg::REG_FRAME_COUNT: frame_count_r <= cfg_wdata[6:0];
        default:                    max_len_r <= max_len_r;
      endcase
    end
  end

  // latch the transaction
  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_item;
  end

  // request checks
  always_comb begin
    n7 = frame_count_r;
    if (n7 > 7'(ACT_MAX)) n7 = 7'(ACT_MAX);
    n_c    = CW'(n7);
    seg_ok = {5'd0, req_r.segment_id} < 9'(NUM_SEGMENTS);
    len_ok = req_r.value_length < max_len_r;
    sel_ok = {1'b0, req_r.frame_sel} < n7;
  end

  // status toward the controller
  always_comb begin
    stat.need_scan = 1'b0;
    if (n7 != 7'd0) begin
      case (req_r.opcode)
        pclce_pkg::OP_LOOKUP:  stat.need_scan = seg_ok;
        pclce_pkg::OP_INSERT:  stat.need_scan = seg_ok && len_ok;
        pclce_pkg::OP_UPDATE:  stat.need_scan = seg_ok && len_ok && sel_ok;
        pclce_pkg::OP_DROP:    stat.need_scan = seg_ok;
        pclce_pkg::OP_JOURNAL: stat.need_scan = 1'b1;
        default:               stat.need_scan = 1'b0;
      endcase
    end
    stat.issue_last = (req_r.opcode == pclce_pkg::OP_UPDATE) || (addr_r + CW'(1) == n_c);
    stat.hit_stop   = eval_vld_r && (req_r.opcode == pclce_pkg::OP_LOOKUP) &&
                      !found_r && e_valid && e_seg_eq && e_key_eq;
  end

  // scan address and read pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_vld_r <= 1'b0;
    end else begin
      eval_vld_r <= cmd.issue;
    end
    if (cmd.scan_start) begin
      addr_r <= (req_r.opcode == pclce_pkg::OP_UPDATE) ? CW'(req_r.frame_sel) : '0;
    end else if (cmd.issue) begin
      addr_r <= addr_r + CW'(1);
    end
    if (cmd.issue) eval_idx_r <= addr_r[FW-1:0];
  end

  // frame memory, one read and one write port
  always_ff @(posedge clk) begin
    if (cmd.issue) rd_q <= ram[addr_r[FW-1:0]];
    if (wr_en) ram[wr_idx] <= wr_data;
  end

  // per-frame compare at the evaluation stage
  always_comb begin
    e_valid   = valid_r[eval_idx_r];
    e_dirty   = dirty_r[eval_idx_r];
    e_seg_eq  = rd_q.seg == req_r.segment_id;
    e_key_eq  = rd_q.key == req_r.page_key;
    lu_better = !best_vld_r || (rd_q.last_use < best_data_r.last_use) ||
                ((rd_q.last_use == best_data_r.last_use) && (rd_q.seg > best_data_r.seg));
  end

  // result of the commit step and of journal emission
  always_comb begin
    emit_vld  = 1'b0;
    emit_item = '0;
    wr_en     = 1'b0;
    wr_idx    = hit_idx_r;
    wr_dirty  = 1'b0;
    wr_data.seg      = req_r.segment_id;
    wr_data.key      = req_r.page_key;
    wr_data.stamp    = req_r.value_stamp;
    wr_data.last_use = req_r.now_time;
    // journal: a newly found dirty page releases the held one
    if (eval_vld_r && (req_r.opcode == pclce_pkg::OP_JOURNAL) && e_valid && e_dirty &&
        found_r) begin
      emit_vld            = 1'b1;
      emit_item.status    = pclce_pkg::ST_OK;
      emit_item.frame_out = 6'(hit_idx_r);
      emit_item.seg_out   = hit_data_r.seg;
      emit_item.key_out   = hit_data_r.key;
      emit_item.stamp_out = hit_data_r.stamp;
    end
    if (cmd.commit) begin
      emit_vld              = 1'b1;
      emit_item.last_of_run = 1'b1;
      case (req_r.opcode)
        pclce_pkg::OP_LOOKUP: begin
          emit_item.seg_out = req_r.segment_id;
          emit_item.key_out = req_r.page_key;
          if (found_r) begin
            emit_item.status    = pclce_pkg::ST_OK;
            emit_item.frame_out = 6'(hit_idx_r);
            emit_item.stamp_out = hit_data_r.stamp;
          end else begin
            emit_item.status = pclce_pkg::ST_MISS;
          end
        end
        pclce_pkg::OP_INSERT: begin
          emit_item.seg_out = req_r.segment_id;
          emit_item.key_out = req_r.page_key;
          wr_dirty          = req_r.dirty_in;
          if (!seg_ok) begin
            emit_item.status = pclce_pkg::ST_MISS;
          end else if (!len_ok) begin
            emit_item.status = pclce_pkg::ST_LONG;
          end else if (found_r) begin
            wr_en               = 1'b1;
            emit_item.status    = pclce_pkg::ST_OK;
            emit_item.frame_out = 6'(hit_idx_r);
            emit_item.stamp_out = req_r.value_stamp;
          end else if (best_vld_r) begin
            wr_en                 = 1'b1;
            wr_idx                = best_idx_r;
            emit_item.status      = pclce_pkg::ST_OK;
            emit_item.frame_out   = 6'(best_idx_r);
            emit_item.stamp_out   = req_r.value_stamp;
            emit_item.evicted     = 1'b1;
            emit_item.evicted_seg = best_data_r.seg;
            emit_item.evicted_key = best_data_r.key;
          end else begin
            emit_item.status = pclce_pkg::ST_FULL;
          end
        end
        pclce_pkg::OP_UPDATE: begin
          emit_item.frame_out = req_r.frame_sel;
          emit_item.seg_out   = req_r.segment_id;
          wr_idx              = FW'(req_r.frame_sel);
          wr_dirty            = 1'b1;
          wr_data.key         = hit_data_r.key;
          wr_data.stamp       = req_r.now_time;
          if (!seg_ok) begin
            emit_item.status = pclce_pkg::ST_MISS;
          end else if (!len_ok) begin
            emit_item.status = pclce_pkg::ST_LONG;
          end else if (found_r) begin
            wr_en               = 1'b1;
            emit_item.status    = pclce_pkg::ST_OK;
            emit_item.key_out   = hit_data_r.key;
            emit_item.stamp_out = req_r.now_time;
          end else begin
            emit_item.status = pclce_pkg::ST_MISS;
          end
        end
        pclce_pkg::OP_DROP: begin
          emit_item.seg_out = req_r.segment_id;
          emit_item.status  = any_r ? pclce_pkg::ST_OK : pclce_pkg::ST_MISS;
        end
        pclce_pkg::OP_JOURNAL: begin
          if (found_r) begin
            emit_item.status    = pclce_pkg::ST_OK;
            emit_item.frame_out = 6'(hit_idx_r);
            emit_item.seg_out   = hit_data_r.seg;
            emit_item.key_out   = hit_data_r.key;
            emit_item.stamp_out = hit_data_r.stamp;
          end else begin
            emit_item.status = pclce_pkg::ST_NODIRTY;
          end
        end
        default: emit_item.status = pclce_pkg::ST_MISS;
      endcase
    end
  end

  // scan trackers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found_r    <= 1'b0;
      best_vld_r <= 1'b0;
      any_r      <= 1'b0;
    end else if (eval_vld_r) begin
      case (req_r.opcode)
        pclce_pkg::OP_LOOKUP: begin
          if (!found_r && e_valid && e_seg_eq && e_key_eq) begin
            found_r    <= 1'b1;
            hit_idx_r  <= eval_idx_r;
            hit_data_r <= rd_q;
          end
        end
        pclce_pkg::OP_INSERT: begin
          if (!found_r && !e_valid) begin
            found_r   <= 1'b1;
            hit_idx_r <= eval_idx_r;
          end
          if (!e_dirty && lu_better) begin
            best_vld_r  <= 1'b1;
            best_idx_r  <= eval_idx_r;
            best_data_r <= rd_q;
          end
        end
        pclce_pkg::OP_UPDATE: begin
          if (e_valid && e_seg_eq) begin
            found_r    <= 1'b1;
            hit_data_r <= rd_q;
          end
        end
        pclce_pkg::OP_DROP: begin
          if (e_valid && e_seg_eq) any_r <= 1'b1;
        end
        pclce_pkg::OP_JOURNAL: begin
          if (e_valid && e_dirty) begin
            found_r    <= 1'b1;
            hit_idx_r  <= eval_idx_r;
            hit_data_r <= rd_q;
          end
        end
        default: any_r <= any_r;
      endcase
    end
  end

  // valid and dirty bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
    end else begin
      if (eval_vld_r && e_valid &&
          (((req_r.opcode == pclce_pkg::OP_DROP) && e_seg_eq) ||
           ((req_r.opcode == pclce_pkg::OP_JOURNAL) && e_dirty))) begin
        valid_r[eval_idx_r] <= 1'b0;
        dirty_r[eval_idx_r] <= 1'b0;
      end
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
        dirty_r[wr_idx] <= wr_dirty;
      end
    end
  end

  // result register, one cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit_vld;
    end
    if (emit_vld) out_r <= emit_item;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

// ===== rtl/core/page_cache_lru_clean_evict.sv =====
// Top level of the page cache with LRU clean eviction and dirty journal.
// Depends on pclce_pkg, pclce_ctrl and pclce_dp.
//
// A transaction is taken when start is high and busy low; the block then works
// on it alone. Lookup, insert, drop and journal scan the active frames through
// the single read port of the frame memory, one frame a cycle (lookup stops at
// its first hit); update reads one frame, and a refused or unknown transaction
// reads none. Results appear for one cycle on out_valid and cannot be stalled;
// a journal gives one result per dirty page, the final one with last_of_run
// set, and busy falls in the cycle the final result is shown.
`default_nettype none
module page_cache_lru_clean_evict #(
  parameter int NUM_FRAMES   = pclce_pkg::NUM_FRAMES_DEF,
  parameter int NUM_SEGMENTS = pclce_pkg::NUM_SEGMENTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire pclce_pkg::in_item_t              in_item,
  output logic                                  out_valid,
  output pclce_pkg::out_item_t                  out_item,
  input  wire logic                             cfg_we,
  input  wire logic [pclce_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [pclce_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  pclce_pkg::dp_cmd_t  cmd;
  pclce_pkg::dp_stat_t stat;

  pclce_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  pclce_dp #(
    .NUM_FRAMES   (NUM_FRAMES),
    .NUM_SEGMENTS (NUM_SEGMENTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ===== rtl/core/pclce_checker.sv =====
// Port-level checker for the page cache, bound to the top level.
// Depends on pclce_pkg.
`default_nettype none
module pclce_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 out_valid,
  input wire pclce_pkg::out_item_t out_item
);

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy did not rise after accept");

  // the end of a transaction shows its final result
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid && out_item.last_of_run)
    else $error("busy fell without a final result");

  // a final result closes the transaction
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_of_run |-> !busy)
    else $error("final result while still busy");

  // more results follow a non-final one
  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_of_run |-> busy)
    else $error("non-final result with block idle");

  // an eviction only comes with a successful insert
  a_evict_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.evicted |-> out_item.status == pclce_pkg::ST_OK)
    else $error("eviction reported with a failing status");

endmodule

bind page_cache_lru_clean_evict pclce_checker u_pclce_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire

// ===== bench/tb_page_cache_lru_clean_evict.sv =====
// Self-checking testbench for page_cache_lru_clean_evict.
// Depends on pclce_pkg and the page_cache_lru_clean_evict RTL; a scoreboard class
// predicts every result of the frame store and checks it against the block.
`timescale 1ns / 1ps

class cache_scoreboard;
  logic [7:0]  max_len;
  logic [6:0]  frames_cfg;
  bit          fr_valid[64];
  bit          fr_dirty[64];
  logic [3:0]  fr_seg[64];
  logic [15:0] fr_key[64];
  logic [63:0] fr_stamp[64];
  logic [63:0] fr_last_use[64];
  pclce_pkg::out_item_t pending[$];
  int          errors;

  function new();
    max_len    = pclce_pkg::MAX_LEN_RST;
    frames_cfg = pclce_pkg::FRAME_COUNT_RST;
    errors     = 0;
    for (int f = 0; f < 64; f++) begin
      fr_valid[f] = 0;
      fr_dirty[f] = 0;
      fr_seg[f] = '0;
      fr_key[f] = '0;
      fr_stamp[f] = '0;
      fr_last_use[f] = '0;
    end
  endfunction

  task report(string msg);
    $display("%0t ERROR: %s", $time, msg);
    errors++;
  endtask

  function void write_reg(logic [pclce_pkg::CFG_IDX_W-1:0] idx,
                          logic [pclce_pkg::CFG_DATA_W-1:0] data);
    if (idx == pclce_pkg::REG_MAX_LEN) max_len = data;
    else if (idx == pclce_pkg::REG_FRAME_COUNT) frames_cfg = data[6:0];
  endfunction

  function void push(logic [2:0] st, int frame, logic [3:0] sg, logic [15:0] ky,
                     logic [63:0] stp, bit ev, logic [3:0] evs, logic [15:0] evk,
                     bit last);
    pclce_pkg::out_item_t r;
    r.status = st;
    r.frame_out = frame[5:0];
    r.seg_out = sg;
    r.key_out = ky;
    r.stamp_out = stp;
    r.evicted = ev;
    r.evicted_seg = evs;
    r.evicted_key = evk;
    r.last_of_run = last;
    pending.push_back(r);
  endfunction

  // Compute the results of one accepted transaction and update the store.
  function void note(pclce_pkg::in_item_t t);
    int  n;
    int  slot;
    int  lastf;
    bit  found;
    bit  any;
    n = (frames_cfg > 64) ? 64 : int'(frames_cfg);
    case (t.opcode)
      pclce_pkg::OP_LOOKUP: begin
        for (int f = 0; f < n; f++)
          if (fr_valid[f] && fr_seg[f] == t.segment_id && fr_key[f] == t.page_key) begin
            push(pclce_pkg::ST_OK, f, t.segment_id, t.page_key, fr_stamp[f], 0, 0, 0, 1);
            return;
          end
        push(pclce_pkg::ST_MISS, 0, t.segment_id, t.page_key, 0, 0, 0, 0, 1);
      end
      pclce_pkg::OP_INSERT: begin
        if (!(t.value_length < max_len)) begin
          push(pclce_pkg::ST_LONG, 0, t.segment_id, t.page_key, 0, 0, 0, 0, 1);
          return;
        end
        found = 0;
        slot = 0;
        for (int f = 0; f < n && !found; f++)
          if (!fr_valid[f]) begin
            slot = f;
            found = 1;
          end
        if (found) begin
          push(pclce_pkg::ST_OK, slot, t.segment_id, t.page_key, t.value_stamp,
               0, 0, 0, 1);
        end else begin
          // pick the oldest clean page; ties go to the higher segment, then lower frame
          for (int f = 0; f < n; f++)
            if (!fr_dirty[f] && (!found || fr_last_use[f] < fr_last_use[slot] ||
                (fr_last_use[f] == fr_last_use[slot] && fr_seg[f] > fr_seg[slot]))) begin
              slot = f;
              found = 1;
            end
          if (!found) begin
            push(pclce_pkg::ST_FULL, 0, t.segment_id, t.page_key, 0, 0, 0, 0, 1);
            return;
          end
          push(pclce_pkg::ST_OK, slot, t.segment_id, t.page_key, t.value_stamp, 1,
               fr_seg[slot], fr_key[slot], 1);
        end
        fr_valid[slot] = 1;
        fr_dirty[slot] = t.dirty_in;
        fr_seg[slot] = t.segment_id;
        fr_key[slot] = t.page_key;
        fr_stamp[slot] = t.value_stamp;
        fr_last_use[slot] = t.now_time;
      end
      pclce_pkg::OP_UPDATE: begin
        if (!(t.value_length < max_len))
          push(pclce_pkg::ST_LONG, t.frame_sel, t.segment_id, 0, 0, 0, 0, 0, 1);
        else if (t.frame_sel >= n || !fr_valid[t.frame_sel] ||
                 fr_seg[t.frame_sel] != t.segment_id)
          push(pclce_pkg::ST_MISS, t.frame_sel, t.segment_id, 0, 0, 0, 0, 0, 1);
        else begin
          fr_stamp[t.frame_sel] = t.now_time;
          fr_last_use[t.frame_sel] = t.now_time;
          fr_dirty[t.frame_sel] = 1;
          push(pclce_pkg::ST_OK, t.frame_sel, t.segment_id, fr_key[t.frame_sel],
               t.now_time, 0, 0, 0, 1);
        end
      end
      pclce_pkg::OP_DROP: begin
        any = 0;
        for (int f = 0; f < n; f++)
          if (fr_valid[f] && fr_seg[f] == t.segment_id) begin
            fr_valid[f] = 0;
            fr_dirty[f] = 0;
            any = 1;
          end
        push(any ? pclce_pkg::ST_OK : pclce_pkg::ST_MISS, 0, t.segment_id,
             0, 0, 0, 0, 0, 1);
      end
      pclce_pkg::OP_JOURNAL: begin
        any = 0;
        lastf = 0;
        for (int f = 0; f < n; f++)
          if (fr_valid[f] && fr_dirty[f]) begin
            lastf = f;
            any = 1;
          end
        if (!any) begin
          push(pclce_pkg::ST_NODIRTY, 0, 0, 0, 0, 0, 0, 0, 1);
          return;
        end
        for (int f = 0; f < n; f++)
          if (fr_valid[f] && fr_dirty[f]) begin
            push(pclce_pkg::ST_OK, f, fr_seg[f], fr_key[f], fr_stamp[f], 0, 0, 0,
                 f == lastf);
            fr_valid[f] = 0;
            fr_dirty[f] = 0;
          end
      end
      default: push(pclce_pkg::ST_MISS, 0, 0, 0, 0, 0, 0, 0, 1);
    endcase
  endfunction

  task cmp(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Compare one result with the oldest expectation.
  task check(pclce_pkg::out_item_t r);
    pclce_pkg::out_item_t e;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result %p", r));
      return;
    end
    e = pending.pop_front();
    cmp("status", r.status, e.status);
    cmp("frame_out", r.frame_out, e.frame_out);
    cmp("seg_out", r.seg_out, e.seg_out);
    cmp("key_out", r.key_out, e.key_out);
    cmp("stamp_out", r.stamp_out, e.stamp_out);
    cmp("evicted", r.evicted, e.evicted);
    cmp("evicted_seg", r.evicted_seg, e.evicted_seg);
    cmp("evicted_key", r.evicted_key, e.evicted_key);
    cmp("last_of_run", r.last_of_run, e.last_of_run);
  endtask
endclass

module tb_page_cache_lru_clean_evict;
  localparam int STALL_LIMIT = 5000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  pclce_pkg::in_item_t   in_item = '0;
  logic                  out_valid;
  pclce_pkg::out_item_t  out_item;
  logic                  cfg_we = 1'b0;
  logic [pclce_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [pclce_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  cache_scoreboard sb = new();
  int  idle_pct = 0;
  int  stall_cnt = 0;
  int  cur_max = 10;

  page_cache_lru_clean_evict u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Check results first, then note a newly accepted transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check(out_item);
      if (start && !busy) sb.note(in_item);
      if (out_valid || (start && !busy)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk) begin
    if (stall_cnt >= STALL_LIMIT) begin
      $display("page_cache_lru_clean_evict test failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Hold start with the item until the block takes it.
  task automatic send(pclce_pkg::in_item_t t);
    @(negedge clk);
    start <= 1'b1;
    in_item <= t;
    do @(posedge clk); while (busy);
    if ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
  endtask

  task automatic op(logic [2:0] opc, logic [3:0] sg, logic [15:0] ky, logic [63:0] stp,
                    logic [63:0] nw, bit dty, logic [7:0] len, logic [5:0] sel);
    pclce_pkg::in_item_t t;
    t.opcode = opc;
    t.segment_id = sg;
    t.page_key = ky;
    t.value_stamp = stp;
    t.now_time = nw;
    t.dirty_in = dty;
    t.value_length = len;
    t.frame_sel = sel;
    send(t);
  endtask

  // Drain outstanding results and let the block settle before a register write.
  task automatic quiesce();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [pclce_pkg::CFG_IDX_W-1:0] idx,
                           logic [pclce_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
    if (idx == pclce_pkg::REG_MAX_LEN) cur_max = data;
  endtask

  // Random transaction biased toward a few segments and keys so lookups hit.
  task automatic rand_op();
    int          w;
    logic [2:0]  opc;
    logic [3:0]  sg;
    logic [15:0] ky;
    logic [63:0] nw;
    logic [7:0]  len;
    logic [5:0]  sel;
    w = $urandom_range(0, 99);
    if (w < 25) opc = pclce_pkg::OP_LOOKUP;
    else if (w < 62) opc = pclce_pkg::OP_INSERT;
    else if (w < 82) opc = pclce_pkg::OP_UPDATE;
    else if (w < 88) opc = pclce_pkg::OP_DROP;
    else if (w < 95) opc = pclce_pkg::OP_JOURNAL;
    else opc = 3'($urandom_range(5, 7));
    sg = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 3)) : 4'($urandom);
    ky = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    nw = ($urandom_range(0, 1) == 0) ? 64'($urandom_range(0, 3)) : rand64();
    if ($urandom_range(0, 9) < 8 && cur_max > 0) len = 8'($urandom_range(0, cur_max - 1));
    else len = 8'($urandom);
    sel = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 7)) : 6'($urandom);
    op(opc, sg, ky, rand64(), nw, 1'($urandom), len, sel);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: basic operations at reset configuration
    op(pclce_pkg::OP_LOOKUP, 4'd0, 16'd0, '0, '0, 0, 8'd0, 6'd0);
    op(pclce_pkg::OP_INSERT, 4'd0, 16'h0000, '1, 64'd5, 0, 8'd9, 6'd0);
    op(pclce_pkg::OP_INSERT, 4'd15, 16'hFFFF, 64'h0123_4567_89AB_CDEF, '1, 1, 8'd0, 6'd0);
    op(pclce_pkg::OP_LOOKUP, 4'd15, 16'hFFFF, '0, '0, 0, 8'd0, 6'd0);
    op(pclce_pkg::OP_LOOKUP, 4'd0, 16'h0000, '0, '0, 0, 8'd0, 6'd0);
    op(pclce_pkg::OP_INSERT, 4'd1, 16'd3, '0, '0, 0, 8'd10, 6'd0);
    op(pclce_pkg::OP_INSERT, 4'd1, 16'd3, '0, '0, 0, 8'd255, 6'd0);
    op(pclce_pkg::OP_UPDATE, 4'd0, 16'd0, '0, 64'hFFFF_0000_FFFF_0000, 0, 8'd0, 6'd0);
    op(pclce_pkg::OP_UPDATE, 4'd3, 16'd0, '0, 64'd1, 0, 8'd0, 6'd1);
    op(pclce_pkg::OP_UPDATE, 4'd0, 16'd0, '0, 64'd1, 0, 8'd0, 6'd63);
    op(pclce_pkg::OP_UPDATE, 4'd0, 16'd0, '0, 64'd1, 0, 8'd200, 6'd0);
    op(pclce_pkg::OP_DROP, 4'd7, 16'd0, '0, '0, 0, 8'd0, 6'd0);
    op(pclce_pkg::OP_JOURNAL, 4'd0, 16'd0, '0, '0, 0, 8'd0, 6'd0);
    op(pclce_pkg::OP_JOURNAL, 4'd0, 16'd0, '0, '0, 0, 8'd0, 6'd0);
    op(pclce_pkg::OP_DROP, 4'd15, 16'd0, '0, '0, 0, 8'd0, 6'd0);
    op(3'd5, 4'd1, 16'd1, '0, '0, 0, 8'd0, 6'd0);
    op(3'd6, 4'd1, 16'd1, '0, '0, 0, 8'd0, 6'd0);
    op(3'd7, 4'd1, 16'd1, '0, '0, 0, 8'd0, 6'd0);

    // directed: two frames, clean eviction with a tie, then a full store
    quiesce();
    write_reg(pclce_pkg::REG_FRAME_COUNT, 8'd2);
    op(pclce_pkg::OP_INSERT, 4'd2, 16'd10, 64'd1, 64'd7, 0, 8'd0, 6'd0);
    op(pclce_pkg::OP_INSERT, 4'd9, 16'd11, 64'd2, 64'd7, 0, 8'd0, 6'd0);
    op(pclce_pkg::OP_INSERT, 4'd4, 16'd12, 64'd3, 64'd8, 1, 8'd0, 6'd0);
    op(pclce_pkg::OP_INSERT, 4'd5, 16'd13, 64'd4, 64'd9, 1, 8'd0, 6'd0);
    op(pclce_pkg::OP_INSERT, 4'd5, 16'd14, 64'd4, 64'd9, 0, 8'd0, 6'd0);
    quiesce();
    write_reg(pclce_pkg::REG_FRAME_COUNT, 8'd0);
    op(pclce_pkg::OP_INSERT, 4'd1, 16'd1, 64'd1, 64'd1, 0, 8'd0, 6'd0);
    op(pclce_pkg::OP_LOOKUP, 4'd4, 16'd12, '0, '0, 0, 8'd0, 6'd0);

    // random phase: small store, long values allowed, sender idles a third
    quiesce();
    write_reg(pclce_pkg::REG_MAX_LEN, 8'd255);
    write_reg(pclce_pkg::REG_FRAME_COUNT, 8'd8);
    idle_pct = 33;
    repeat (40) rand_op();

    // random phase: one frame, only empty values, sender idles mostly
    quiesce();
    write_reg(pclce_pkg::REG_MAX_LEN, 8'd1);
    write_reg(pclce_pkg::REG_FRAME_COUNT, 8'd1);
    idle_pct = 70;
    repeat (40) rand_op();

    // random phase: full store, fill with dirty pages and journal them all
    quiesce();
    write_reg(pclce_pkg::REG_MAX_LEN, 8'd128);
    write_reg(pclce_pkg::REG_FRAME_COUNT, 8'd64);
    idle_pct = 0;
    for (int i = 0; i < 64; i++)
      op(pclce_pkg::OP_INSERT, 4'($urandom), 16'($urandom), rand64(), rand64(), 1,
         8'd0, 6'd0);
    op(pclce_pkg::OP_INSERT, 4'd3, 16'd3, rand64(), rand64(), 0, 8'd0, 6'd0);
    op(pclce_pkg::OP_JOURNAL, 4'd0, 16'd0, '0, '0, 0, 8'd0, 6'd0);
    repeat (40) rand_op();

    quiesce();
    if (sb.errors == 0) $display("page_cache_lru_clean_evict test passed");
    else $display("page_cache_lru_clean_evict test failed");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/pclce_pkg.sv
rtl/core/pclce_ctrl.sv
rtl/core/pclce_dp.sv
rtl/core/page_cache_lru_clean_evict.sv
rtl/core/pclce_checker.sv
bench/tb_page_cache_lru_clean_evict.sv
